// ===== sv/nested_grid_cell_locator_macros.svh =====
// Assertion helpers for the nested grid cell locator.
`ifndef NESTED_GRID_CELL_LOCATOR_MACROS_SVH
`define NESTED_GRID_CELL_LOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define NGCL_ASSERT_CLK(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("ngcl assertion failed");
`define NGCL_ASSERT(name, prop) `NGCL_ASSERT_CLK(name, clk_i, rst_ni, prop)
`else
`define NGCL_ASSERT_CLK(name, clk, rstn, prop)
`define NGCL_ASSERT(name, prop)
`endif
`endif

// ===== sv/ngcl_pkg.sv =====
package ngcl_pkg;

  localparam int MaxGrids  = 16;
  localparam int MaxCells  = 16;
  localparam int MaxLevels = 8;
  localparam int Axes      = 3;
  localparam int Slots     = MaxCells + 1;
  localparam int TolW      = 16;
  localparam int BndDepth  = MaxGrids * Axes * Slots;
  localparam int BndAw     = $clog2(BndDepth);
  localparam int ShpDepth  = MaxGrids * Axes;
  localparam int ShpAw     = $clog2(ShpDepth);
  localparam int LnkDepth  = MaxGrids * MaxCells * MaxCells * MaxCells;
  localparam int LnkAw     = $clog2(LnkDepth);
  localparam int NumW      = 33;
  localparam int DenW      = 31;

  typedef enum logic [1:0] {
    REQ_BOUNDARY = 2'd0,
    REQ_LINK     = 2'd1,
    REQ_SHAPE    = 2'd2,
    REQ_LOCATE   = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    S_IDLE, S_SHAPE, S_SHAPE_W, S_DIV, S_RDLO, S_RDHI, S_RDHI_W, S_EVAL,
    S_MUL, S_TOL, S_AXEND, S_LINK, S_LINK_W, S_FAIL, S_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [3:0]         grid_sel;
    logic [1:0]         axis_sel;
    logic [4:0]         slot;
    logic [3:0]         cell_x;
    logic [3:0]         cell_y;
    logic [3:0]         cell_z;
    logic signed [31:0] load_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [2:0]         dir_positive;
  } in_item_t;

  typedef struct packed {
    logic [2:0] level;
    logic [3:0] grid_num;
    logic [3:0] index_x;
    logic [3:0] index_y;
    logic [3:0] index_z;
    logic       out_of_cell;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] cube;
    logic [4:0]         cnt;
  } shape_t;

  function automatic logic [ShpAw-1:0] shp_addr(logic [3:0] g, logic [1:0] a);
    return ShpAw'(int'(g) * Axes + int'(a));
  endfunction

  function automatic logic [BndAw-1:0] bnd_addr(logic [3:0] g, logic [1:0] a,
                                                logic [4:0] s);
    return BndAw'((int'(g) * Axes + int'(a)) * Slots + int'(s));
  endfunction

endpackage

// ===== sv/ngcl_div.sv =====
module ngcl_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ngcl_pkg::NumW-1:0]     num_i,
  input  logic [ngcl_pkg::DenW-1:0]     den_i,
  output logic                          done_o,
  output logic [ngcl_pkg::NumW-1:0]     quot_o
);

  logic                         busy_q, busy_d, done_q, done_d;
  logic [5:0]                   cnt_q, cnt_d;
  logic [ngcl_pkg::DenW-1:0]    rem_q, rem_d, den_q, den_d;
  logic [ngcl_pkg::NumW-1:0]    quo_q, quo_d;
  logic [ngcl_pkg::DenW:0]      trial;
  logic                         fits;

  // one quotient bit per cycle, restoring
  assign trial = {rem_q, quo_q[ngcl_pkg::NumW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = fits ? ngcl_pkg::DenW'(trial - {1'b0, den_q})
                   : ngcl_pkg::DenW'(trial);
      quo_d = {quo_q[ngcl_pkg::NumW-2:0], fits};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(ngcl_pkg::NumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== sv/ngcl_store.sv =====
module ngcl_store (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  ngcl_pkg::in_item_t            item_i,
  input  logic [ngcl_pkg::BndAw-1:0]    bnd_raddr_i,
  input  logic [ngcl_pkg::ShpAw-1:0]    shp_raddr_i,
  input  logic [ngcl_pkg::LnkAw-1:0]    lnk_raddr_i,
  output logic signed [31:0]            bnd_rdata_o,
  output ngcl_pkg::shape_t              shp_rdata_o,
  output logic [3:0]                    lnk_rdata_o
);

  logic signed [31:0] bnd_mem [ngcl_pkg::BndDepth];
  ngcl_pkg::shape_t   shp_mem [ngcl_pkg::ShpDepth];
  logic [3:0]         lnk_mem [ngcl_pkg::LnkDepth];

  logic in_range, bnd_we, shp_we, lnk_we;
  logic [ngcl_pkg::BndAw-1:0] bnd_waddr;
  logic [ngcl_pkg::ShpAw-1:0] shp_waddr;
  logic [ngcl_pkg::LnkAw-1:0] lnk_waddr;

  // drop loads that point outside the tables
  assign in_range = (int'(item_i.grid_sel) < ngcl_pkg::MaxGrids)
                 && (int'(item_i.axis_sel) < ngcl_pkg::Axes)
                 && (int'(item_i.slot) <= ngcl_pkg::MaxCells);
  assign bnd_we = we_i && (item_i.req_type == ngcl_pkg::REQ_BOUNDARY) && in_range;
  assign shp_we = we_i && (item_i.req_type == ngcl_pkg::REQ_SHAPE) && in_range;
  assign lnk_we = we_i && (item_i.req_type == ngcl_pkg::REQ_LINK);

  assign bnd_waddr = ngcl_pkg::bnd_addr(item_i.grid_sel, item_i.axis_sel, item_i.slot);
  assign shp_waddr = ngcl_pkg::shp_addr(item_i.grid_sel, item_i.axis_sel);
  assign lnk_waddr = {item_i.grid_sel, item_i.cell_x, item_i.cell_y, item_i.cell_z};

  always_ff @(posedge clk_i) begin
    if (bnd_we) begin
      bnd_mem[bnd_waddr] <= item_i.load_value;
    end
    bnd_rdata_o <= bnd_mem[bnd_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (shp_we) begin
      shp_mem[shp_waddr] <= '{cube: item_i.load_value, cnt: item_i.slot};
    end
    shp_rdata_o <= shp_mem[shp_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (lnk_we) begin
      lnk_mem[lnk_waddr] <= item_i.load_value[3:0];
    end
    lnk_rdata_o <= lnk_mem[lnk_raddr_i];
  end

endmodule

// ===== sv/nested_grid_cell_locator.sv =====
// Nested grid cell locator. Load beats (boundary, cell link, axis shape) are
// taken while idle, give no result and do not stall the input. A locate beat
// walks the grid hierarchy from grid 0 and gives one result beat per level,
// the deepest or the failing one flagged last. Each axis of each level runs
// shape and origin reads, the serial divider that forms the cell index, two
// passes of boundary reads around the edge nudge, the tolerance multiply and
// compare when the point misses its cell, and a step to store the index. A
// level ends with the link lookup and the result. The run length is set by
// the shared divider and the single boundary memory port; a stalled receiver
// adds its stall time. The input is stalled for the whole run. The output
// register lets a result wait while the search goes on to the next level.
// All tables power up undefined; load every entry a search will touch. The
// tolerance register may be written only while idle.
module nested_grid_cell_locator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ngcl_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ngcl_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [15:0]         cfg_data_i
);

  `include "nested_grid_cell_locator_macros.svh"

  ngcl_pkg::state_e state_q, state_d;

  logic [15:0]         tol_q, tol_d;
  ngcl_pkg::in_item_t  item_q, item_d;
  logic [2:0]          lvl_q, lvl_d;
  logic [3:0]          g_q, g_d;
  logic [1:0]          ax_q, ax_d;
  logic signed [31:0]  cube_q, cube_d;
  logic [4:0]          cnt_q, cnt_d;
  logic                neg_q, neg_d;
  logic signed [5:0]   idx_q, idx_d;
  logic                phase_q, phase_d;
  logic                down_q, down_d;
  logic signed [31:0]  lo_q, lo_d, hi_q, hi_d;
  logic [32:0]         miss_q, miss_d;
  logic [46:0]         prod_q, prod_d;
  logic [3:0]          ix_q [3];
  logic [3:0]          ix_d [3];
  logic [3:0]          link_q, link_d;
  ngcl_pkg::out_item_t res_q, res_d;
  logic                out_valid_q, out_valid_d;
  ngcl_pkg::out_item_t out_q, out_d;

  logic                       accept;
  logic                       div_start, div_done;
  logic [ngcl_pkg::NumW-1:0]  div_num, div_quot;
  logic [ngcl_pkg::BndAw-1:0] bnd_raddr;
  logic [ngcl_pkg::ShpAw-1:0] shp_raddr;
  logic [ngcl_pkg::LnkAw-1:0] lnk_raddr;
  logic signed [31:0]         bnd_rdata;
  ngcl_pkg::shape_t           shp_rdata;
  logic [3:0]                 lnk_rdata;

  logic signed [31:0] p;
  logic               up;
  logic signed [33:0] diff;
  logic [33:0]        diff_mag;
  logic               shape_bad, div_bad, out_free;
  logic signed [5:0]  cnt_s, nudge_idx;
  logic               in_cell, tol_ok, idx_bad, link_err, link_last;
  logic signed [32:0] miss_lo, miss_hi;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ngcl_pkg::S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  // per-axis operands of the item in flight
  always_comb begin
    case (ax_q)
      2'd1:    p = item_q.pos_y;
      2'd2:    p = item_q.pos_z;
      default: p = item_q.pos_x;
    endcase
  end
  assign up = item_q.dir_positive[ax_q];

  assign diff      = 34'(p) - 34'(bnd_rdata);
  assign diff_mag  = diff[33] ? 34'(-diff) : 34'(diff);
  assign div_num   = diff_mag[ngcl_pkg::NumW-1:0];
  assign shape_bad = shp_rdata.cube[31] || (shp_rdata.cube == '0);
  assign div_bad   = (neg_q && (div_quot != '0)) || (div_quot > 33'(cnt_q));
  assign cnt_s     = $signed({1'b0, cnt_q});

  // exact edge hits move toward the direction of travel
  always_comb begin
    nudge_idx = idx_q;
    if ((p == lo_q) && !up) begin
      nudge_idx = idx_q - 6'sd1;
    end else if ((idx_q < cnt_s) && (p == hi_q) && up) begin
      nudge_idx = idx_q + 6'sd1;
    end
  end

  assign in_cell = (idx_q >= 6'sd0) && (idx_q < cnt_s) && (p >= lo_q) && (p <= hi_q);
  assign miss_lo = 33'(lo_q) - 33'(p);
  assign miss_hi = 33'(p) - 33'(hi_q);
  assign tol_ok  = {miss_q, 16'd0} < {2'd0, prod_q};
  assign idx_bad = (idx_q < 6'sd0) || (idx_q >= cnt_s);

  assign link_err  = (lnk_rdata != '0)
                  && ((lvl_q == 3'(ngcl_pkg::MaxLevels - 1))
                  || (int'(lnk_rdata) >= ngcl_pkg::MaxGrids));
  assign link_last = (lnk_rdata == '0) || link_err;

  // memory read addresses
  always_comb begin
    bnd_raddr = ngcl_pkg::bnd_addr(g_q, ax_q, 5'd0);
    shp_raddr = ngcl_pkg::shp_addr(g_q, ax_q);
    lnk_raddr = {g_q, ix_q[0], ix_q[1], ix_q[2]};
    case (state_q)
      ngcl_pkg::S_RDLO: bnd_raddr = ngcl_pkg::bnd_addr(g_q, ax_q, idx_q[4:0]);
      ngcl_pkg::S_RDHI: bnd_raddr = ngcl_pkg::bnd_addr(g_q, ax_q, idx_q[4:0] + 5'd1);
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ngcl_pkg::S_IDLE: begin
        if (accept && (in_item_i.req_type == ngcl_pkg::REQ_LOCATE)) begin
          state_d = ngcl_pkg::S_SHAPE;
        end
      end
      ngcl_pkg::S_SHAPE:   state_d = ngcl_pkg::S_SHAPE_W;
      ngcl_pkg::S_SHAPE_W: state_d = shape_bad ? ngcl_pkg::S_FAIL : ngcl_pkg::S_DIV;
      ngcl_pkg::S_DIV: begin
        if (div_done) begin
          state_d = div_bad ? ngcl_pkg::S_FAIL : ngcl_pkg::S_RDLO;
        end
      end
      ngcl_pkg::S_RDLO:   state_d = ngcl_pkg::S_RDHI;
      ngcl_pkg::S_RDHI:   state_d = ngcl_pkg::S_RDHI_W;
      ngcl_pkg::S_RDHI_W: state_d = ngcl_pkg::S_EVAL;
      ngcl_pkg::S_EVAL: begin
        if (!phase_q) begin
          state_d = ngcl_pkg::S_RDLO;
        end else if (in_cell || (idx_q == cnt_s)) begin
          state_d = ngcl_pkg::S_AXEND;
        end else if (idx_q < 6'sd0) begin
          state_d = ngcl_pkg::S_FAIL;
        end else begin
          state_d = ngcl_pkg::S_MUL;
        end
      end
      ngcl_pkg::S_MUL: state_d = ngcl_pkg::S_TOL;
      ngcl_pkg::S_TOL: state_d = tol_ok ? ngcl_pkg::S_AXEND : ngcl_pkg::S_FAIL;
      ngcl_pkg::S_AXEND: begin
        if (idx_bad) begin
          state_d = ngcl_pkg::S_FAIL;
        end else if (ax_q == 2'd2) begin
          state_d = ngcl_pkg::S_LINK;
        end else begin
          state_d = ngcl_pkg::S_SHAPE;
        end
      end
      ngcl_pkg::S_LINK:   state_d = ngcl_pkg::S_LINK_W;
      ngcl_pkg::S_LINK_W: state_d = ngcl_pkg::S_EMIT;
      ngcl_pkg::S_FAIL:   state_d = ngcl_pkg::S_EMIT;
      ngcl_pkg::S_EMIT: begin
        if (out_free) begin
          state_d = res_q.last ? ngcl_pkg::S_IDLE : ngcl_pkg::S_SHAPE;
        end
      end
      default: state_d = ngcl_pkg::S_IDLE;
    endcase
  end

  // datapath and output register
  always_comb begin
    tol_d       = cfg_valid_i ? cfg_data_i : tol_q;
    item_d      = item_q;
    lvl_d       = lvl_q;
    g_d         = g_q;
    ax_d        = ax_q;
    cube_d      = cube_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    idx_d       = idx_q;
    phase_d     = phase_q;
    down_d      = down_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    miss_d      = miss_q;
    prod_d      = prod_q;
    ix_d        = ix_q;
    link_d      = link_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    div_start   = 1'b0;
    unique case (state_q)
      ngcl_pkg::S_IDLE: begin
        if (accept) begin
          item_d = in_item_i;
          lvl_d  = '0;
          g_d    = '0;
          ax_d   = '0;
        end
      end
      ngcl_pkg::S_SHAPE_W: begin
        cube_d    = shp_rdata.cube;
        cnt_d     = shp_rdata.cnt;
        neg_d     = diff[33];
        div_start = !shape_bad;
      end
      ngcl_pkg::S_DIV: begin
        idx_d   = $signed({1'b0, div_quot[4:0]});
        phase_d = 1'b0;
      end
      ngcl_pkg::S_RDHI:   lo_d = bnd_rdata;
      ngcl_pkg::S_RDHI_W: hi_d = bnd_rdata;
      ngcl_pkg::S_EVAL: begin
        if (!phase_q) begin
          idx_d   = nudge_idx;
          phase_d = 1'b1;
        end else if (!in_cell && (idx_q == cnt_s)) begin
          // upper face of the grid
          idx_d = idx_q - 6'sd1;
        end else if (p < lo_q) begin
          miss_d = miss_lo;
          down_d = 1'b1;
        end else begin
          miss_d = miss_hi;
          down_d = 1'b0;
        end
      end
      ngcl_pkg::S_MUL: prod_d = tol_q * cube_q[30:0];
      ngcl_pkg::S_TOL: begin
        if (tol_ok) begin
          idx_d = down_q ? idx_q - 6'sd1 : idx_q + 6'sd1;
        end
      end
      ngcl_pkg::S_AXEND: begin
        ix_d[ax_q] = idx_q[3:0];
        ax_d       = ax_q + 2'd1;
      end
      ngcl_pkg::S_LINK_W: begin
        link_d = lnk_rdata;
        res_d  = '{level: lvl_q, grid_num: g_q, index_x: ix_q[0], index_y: ix_q[1],
                   index_z: ix_q[2], out_of_cell: link_err, last: link_last};
      end
      ngcl_pkg::S_FAIL: begin
        res_d = '{level: lvl_q, grid_num: g_q, index_x: '0, index_y: '0,
                  index_z: '0, out_of_cell: 1'b1, last: 1'b1};
      end
      ngcl_pkg::S_EMIT: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          lvl_d       = lvl_q + 3'd1;
          g_d         = link_q;
          ax_d        = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ngcl_pkg::S_IDLE;
      tol_q       <= 16'd66;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tol_q       <= tol_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    lvl_q   <= lvl_d;
    g_q     <= g_d;
    ax_q    <= ax_d;
    cube_q  <= cube_d;
    cnt_q   <= cnt_d;
    neg_q   <= neg_d;
    idx_q   <= idx_d;
    phase_q <= phase_d;
    down_q  <= down_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    miss_q  <= miss_d;
    prod_q  <= prod_d;
    ix_q    <= ix_d;
    link_q  <= link_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  ngcl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (shp_rdata.cube[30:0]),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  ngcl_store u_store (
    .clk_i       (clk_i),
    .we_i        (accept),
    .item_i      (in_item_i),
    .bnd_raddr_i (bnd_raddr),
    .shp_raddr_i (shp_raddr),
    .lnk_raddr_i (lnk_raddr),
    .bnd_rdata_o (bnd_rdata),
    .shp_rdata_o (shp_rdata),
    .lnk_rdata_o (lnk_rdata)
  );

  // a result that is not last means the walk goes on
  `NGCL_ASSERT(a_more_levels, (out_valid_o && !out_item_o.last) |-> (state_q != ngcl_pkg::S_IDLE))
  // an error always ends the run
  `NGCL_ASSERT(a_err_last, out_valid_o |-> (!out_item_o.out_of_cell || out_item_o.last))
  // the divider only finishes while the sequencer waits on it
  `NGCL_ASSERT(a_div_wait, div_done |-> (state_q == ngcl_pkg::S_DIV))
  // boundary reads of the first pass start from a valid index
  `NGCL_ASSERT(a_idx_first, (state_q == ngcl_pkg::S_RDLO && !phase_q) |-> (idx_q >= 6'sd0))

endmodule

// ===== test/nested_grid_cell_locator_tb.sv =====
`timescale 1ns / 1ps

module nested_grid_cell_locator_tb;
  import ngcl_pkg::*;

  localparam longint Extent = 64'h40000;  // every search grid spans 0.0 .. 4.0 on each axis
  localparam int     NumUsed = 4;         // grids that the hierarchy walk can reach

  typedef struct {
    in_item_t  beat;
    bit        typed;
    out_item_t want;
  } drill_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b1;
  out_item_t out_item;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [15:0] cfg_data = '0;

  nested_grid_cell_locator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the locator tables; the written flags keep every random
  // search we send inside entries that have been loaded.
  int          bnd_tab [Axes*MaxGrids][Slots];
  bit          bnd_set [Axes*MaxGrids][Slots];
  int          cube_tab[Axes*MaxGrids];
  int          cnt_tab [Axes*MaxGrids];
  bit          shp_set [Axes*MaxGrids];
  bit [3:0]    link_tab[LnkDepth];
  bit          link_set[LnkDepth];
  bit [15:0]   tol_reg = 16'd66;
  bit          touched_unloaded;

  int          layout_cnt[NumUsed][Axes];  // cell counts of the reachable grids
  out_item_t   cell_trail[$];              // results still owed by the locator
  int          mismatches = 0;
  int          rx_busy_pct = 0;
  int          tx_gap_pct = 0;
  int          hold_left = 0;

  // Cell index of p on one grid axis, -1 when the point misses the grid.
  function automatic longint axis_cell(int ga, longint p, bit up);
    longint cnt, cube, idx, miss;
    bit     in_cell;
    if (!shp_set[ga]) touched_unloaded = 1'b1;
    cnt  = cnt_tab[ga];
    cube = cube_tab[ga];
    if (cube <= 0) return -1;
    for (int k = 0; k <= cnt; k++) if (!bnd_set[ga][k]) touched_unloaded = 1'b1;
    idx = (p - bnd_tab[ga][0]) / cube;
    if (idx < 0 || idx > cnt) return -1;
    if (p == bnd_tab[ga][idx] && !up) idx--;
    else if (idx < cnt && p == bnd_tab[ga][idx+1] && up) idx++;
    in_cell = idx >= 0 && idx < cnt && p >= bnd_tab[ga][idx] && p <= bnd_tab[ga][idx+1];
    if (!in_cell) begin
      if (idx == cnt) begin
        idx--;
      end else if (idx < 0 || idx > cnt) begin
        return -1;
      end else if (p < bnd_tab[ga][idx]) begin
        miss = longint'(bnd_tab[ga][idx]) - p;
        if (miss * 65536 < longint'(tol_reg) * cube) idx--;
        else return -1;
      end else begin
        miss = p - longint'(bnd_tab[ga][idx+1]);
        if (miss * 65536 < longint'(tol_reg) * cube) idx++;
        else return -1;
      end
    end
    if (idx < 0 || idx >= cnt) return -1;
    return idx;
  endfunction

  // Walk the hierarchy from grid 0; one result per level visited.
  function automatic void walk_cells(in_item_t it, ref out_item_t res[$]);
    longint    pos[Axes];
    longint    ix[Axes];
    int        g, addr;
    bit        bad;
    bit [3:0]  lnk;
    out_item_t r;
    pos[0] = longint'(it.pos_x);
    pos[1] = longint'(it.pos_y);
    pos[2] = longint'(it.pos_z);
    res.delete();
    g = 0;
    for (int lvl = 0; lvl < MaxLevels; lvl++) begin
      bad = 1'b0;
      for (int a = 0; a < Axes; a++) begin
        ix[a] = axis_cell(g * Axes + a, pos[a], it.dir_positive[a]);
        if (ix[a] < 0) bad = 1'b1;
      end
      r.level    = 3'(lvl);
      r.grid_num = 4'(g);
      if (bad) begin
        r.index_x = '0; r.index_y = '0; r.index_z = '0;
        r.out_of_cell = 1'b1; r.last = 1'b1;
        res.push_back(r);
        return;
      end
      r.index_x = 4'(ix[0]); r.index_y = 4'(ix[1]); r.index_z = 4'(ix[2]);
      addr = ((g * MaxCells + int'(ix[0])) * MaxCells + int'(ix[1])) * MaxCells + int'(ix[2]);
      if (!link_set[addr]) touched_unloaded = 1'b1;
      lnk = link_tab[addr];
      r.out_of_cell = (lnk != 0) && (lvl + 1 >= MaxLevels);
      r.last        = (lnk == 0) || r.out_of_cell;
      res.push_back(r);
      if (r.last) return;
      g = lnk;
    end
  endfunction

  function automatic void apply_load(in_item_t it);
    int ga, addr;
    ga = int'(it.grid_sel) * Axes + int'(it.axis_sel);
    case (req_e'(it.req_type))
      REQ_BOUNDARY: begin
        if (it.axis_sel < Axes && it.slot <= MaxCells) begin
          bnd_tab[ga][it.slot] = it.load_value;
          bnd_set[ga][it.slot] = 1'b1;
        end
      end
      REQ_LINK: begin
        addr = ((int'(it.grid_sel) * MaxCells + int'(it.cell_x)) * MaxCells
                + int'(it.cell_y)) * MaxCells + int'(it.cell_z);
        link_tab[addr] = it.load_value[3:0];
        link_set[addr] = 1'b1;
      end
      REQ_SHAPE: begin
        if (it.axis_sel < Axes && it.slot <= MaxCells) begin
          cube_tab[ga] = it.load_value;
          cnt_tab[ga]  = it.slot;
          shp_set[ga]  = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic in_item_t mk_load(req_e kind, int g, int a, int s, int v);
    in_item_t it;
    it = '0;
    it.req_type   = kind;
    it.grid_sel   = 4'(g);
    it.axis_sel   = 2'(a);
    it.slot       = 5'(s);
    it.load_value = v;
    it.pos_x      = $urandom();  // ignored by loads; toggle anyway
    it.dir_positive = 3'($urandom_range(0, 7));
    return it;
  endfunction

  function automatic in_item_t mk_link(int g, int x, int y, int z, int lnk);
    in_item_t it;
    it = mk_load(REQ_LINK, g, $urandom_range(0, 3), $urandom_range(0, 31),
                 {28'($urandom_range(0, 32'hfffffff)), 4'(lnk)});
    it.cell_x = 4'(x); it.cell_y = 4'(y); it.cell_z = 4'(z);
    return it;
  endfunction

  function automatic in_item_t mk_locate(int px, int py, int pz, int dir);
    in_item_t it;
    it = '0;
    it.req_type     = REQ_LOCATE;
    it.grid_sel     = 4'($urandom_range(0, 15));
    it.slot         = 5'($urandom_range(0, 31));
    it.load_value   = $urandom();
    it.pos_x        = px;
    it.pos_y        = py;
    it.pos_z        = pz;
    it.dir_positive = 3'(dir);
    return it;
  endfunction

  function automatic out_item_t mk_result(int lvl, int g, int x, int y, int z, bit err);
    out_item_t r;
    r.level = 3'(lvl); r.grid_num = 4'(g);
    r.index_x = 4'(x); r.index_y = 4'(y); r.index_z = 4'(z);
    r.out_of_cell = err; r.last = 1'b1;
    return r;
  endfunction

  // Present one beat, hold it until accepted, then book its results.
  task automatic offer(in_item_t it, bit typed, out_item_t want, ref out_item_t res[$]);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < tx_gap_pct)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_item  = it;
    in_valid = 1'b1;
    do @(posedge clk_i); while (in_stall);
    if (it.req_type == REQ_LOCATE) begin
      if (typed) cell_trail.push_back(want);
      else foreach (res[i]) cell_trail.push_back(res[i]);
    end else begin
      apply_load(it);
    end
    @(negedge clk_i);
  endtask

  task automatic send_load(in_item_t it);
    out_item_t none[$];
    offer(it, 1'b0, '0, none);
  endtask

  task automatic drain;
    in_valid = 1'b0;
    while (cell_trail.size() != 0) @(negedge clk_i);
  endtask

  // Write the tolerance only with the locator idle; loads leave no result
  // to wait for, so pause after the drain as well.
  task automatic write_tolerance(bit [15:0] v);
    drain();
    repeat (40) @(negedge clk_i);
    cfg_data  = v;
    cfg_valid = 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    tol_reg = v;
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  // Lay out the reachable grids over the same extent, with jittered edges so
  // that near-edge points exercise the tolerance logic.
  task automatic build_hierarchy;
    int cube, v;
    layout_cnt = '{'{2, 2, 2}, '{3, 1, 2}, '{1, 2, 1}, '{16, 1, 1}};
    for (int g = 0; g < NumUsed; g++) begin
      for (int a = 0; a < Axes; a++) begin
        cube = int'(Extent) / layout_cnt[g][a];
        send_load(mk_load(REQ_SHAPE, g, a, layout_cnt[g][a], cube));
        for (int k = 0; k <= layout_cnt[g][a]; k++) begin
          v = k * cube;
          if (k != 0) v += int'($urandom_range(0, cube / 32)) - cube / 64;
          send_load(mk_load(REQ_BOUNDARY, g, a, k, v));
        end
      end
      for (int x = 0; x < layout_cnt[g][0]; x++)
        for (int y = 0; y < layout_cnt[g][1]; y++)
          for (int z = 0; z < layout_cnt[g][2]; z++)
            send_load(mk_link(g, x, y, z,
                              ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, NumUsed - 1)));
    end
  endtask

  // Pick a coordinate on or near an edge, inside a cell, or anywhere.
  function automatic int pick_coord(int g, int a);
    int ga, k, cube;
    ga   = g * Axes + a;
    k    = $urandom_range(0, cnt_tab[ga]);
    cube = (cube_tab[ga] > 0) ? cube_tab[ga] : 65536;
    case ($urandom_range(0, 9))
      0, 1, 2: return bnd_tab[ga][k];
      3, 4:    return bnd_tab[ga][k] + $urandom_range(1, cube / 2048 + 2);
      5:       return bnd_tab[ga][k] - $urandom_range(1, cube / 2048 + 2);
      6, 7, 8: return bnd_tab[ga][k] + $urandom_range(0, cube - 1);
      default: return $urandom();
    endcase
  endfunction

  // One random beat: mostly searches, some reloads of the live tables,
  // and writes to grids that no link reaches. Returns 0 for ignored beats.
  task automatic random_beat(output bit counted);
    in_item_t  it;
    out_item_t res[$];
    int        g, a, s, pick;
    counted = 1'b1;
    pick = $urandom_range(0, 99);
    if (pick < 74) begin
      do begin
        g = $urandom_range(0, NumUsed - 1);
        it = mk_locate(pick_coord(g, 0), pick_coord(g, 1), pick_coord(g, 2),
                       $urandom_range(0, 7));
        touched_unloaded = 1'b0;
        walk_cells(it, res);
      end while (touched_unloaded);
      offer(it, 1'b0, '0, res);
    end else if (pick < 82) begin
      g = $urandom_range(0, NumUsed - 1);
      a = $urandom_range(0, 2);
      s = $urandom_range(0, layout_cnt[g][a]);
      it = mk_load(REQ_BOUNDARY, g, a, s,
                   ($urandom_range(0, 7) == 0) ? $urandom()
                   : s * (int'(Extent) / layout_cnt[g][a]) + int'($urandom_range(0, 64)) - 32);
      send_load(it);
    end else if (pick < 88) begin
      g = $urandom_range(0, NumUsed - 1);
      send_load(mk_link(g, $urandom_range(0, 15), $urandom_range(0, 15),
                        $urandom_range(0, 15), $urandom_range(0, NumUsed - 1)));
    end else if (pick < 92) begin
      g = $urandom_range(0, NumUsed - 1);
      a = $urandom_range(0, 2);
      send_load(mk_load(REQ_SHAPE, g, a, layout_cnt[g][a],
                        ($urandom_range(0, 3) == 0) ? -$urandom_range(0, 65536)
                        : int'(Extent) / layout_cnt[g][a] + $urandom_range(0, 3)));
    end else if (pick < 96) begin
      // Unreachable grids take any value.
      send_load(mk_load(req_e'($urandom_range(0, 2)), $urandom_range(NumUsed, 15),
                        $urandom_range(0, 2), $urandom_range(0, 16), $urandom()));
    end else begin
      counted = 1'b0;
      if ($urandom_range(0, 1) == 0)
        send_load(mk_load(REQ_BOUNDARY, $urandom_range(0, 15), 3, $urandom_range(0, 31),
                          $urandom()));
      else
        send_load(mk_load(REQ_SHAPE, $urandom_range(0, 15), $urandom_range(0, 2),
                          $urandom_range(17, 31), $urandom()));
    end
  endtask

  // Receiver: random stall runs, plus a long hold-off on request.
  initial begin
    int stall_run;
    stall_run = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (stall_run > 0) begin
        out_stall = 1'b1;
        stall_run--;
      end else begin
        out_stall = 1'b0;
        if ($urandom_range(0, 99) < rx_busy_pct)
          stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(1, 3);
      end
    end
  end

  // Compare each accepted result beat against the oldest expectation.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (cell_trail.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_item);
      end else begin
        want = cell_trail.pop_front();
        if (out_item.level !== want.level || out_item.grid_num !== want.grid_num ||
            out_item.index_x !== want.index_x || out_item.index_y !== want.index_y ||
            out_item.index_z !== want.index_z ||
            out_item.out_of_cell !== want.out_of_cell || out_item.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, out_item);
        end
      end
    end
  end

  initial begin
    #40ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    drill_row_t drill[$];
    out_item_t  res[$];
    bit [15:0]  tol_plan[4];
    bit         counted;
    int         sent;
    int         one = 32'h10000;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: grid 0 is 2x1x1 unit cells, default tolerance.
    rx_busy_pct = 20;
    tx_gap_pct  = 20;
    drill.push_back('{mk_load(REQ_SHAPE, 0, 0, 2, one), 0, '0});
    drill.push_back('{mk_load(REQ_SHAPE, 0, 1, 1, one), 0, '0});
    drill.push_back('{mk_load(REQ_SHAPE, 0, 2, 1, one), 0, '0});
    for (int a = 0; a < Axes; a++)
      for (int k = 0; k <= ((a == 0) ? 2 : 1); k++)
        drill.push_back('{mk_load(REQ_BOUNDARY, 0, a, k, k * one), 0, '0});
    drill.push_back('{mk_link(0, 0, 0, 0, 0), 0, '0});
    drill.push_back('{mk_link(0, 1, 0, 0, 0), 0, '0});
    // Interior point, then exact interior edge nudged each way.
    drill.push_back('{mk_locate(one / 2, one / 2, one / 2, 0), 1, mk_result(0, 0, 0, 0, 0, 0)});
    drill.push_back('{mk_locate(one, one / 2, one / 2, 1), 1, mk_result(0, 0, 1, 0, 0, 0)});
    drill.push_back('{mk_locate(one, one / 2, one / 2, 0), 1, mk_result(0, 0, 0, 0, 0, 0)});
    // Upper face of the grid pulls back into the top cell.
    drill.push_back('{mk_locate(2 * one, one, 0, 7), 1, mk_result(0, 0, 1, 0, 0, 0)});
    // Outside grid and coordinate extremes.
    drill.push_back('{mk_locate(-2 * one, 0, 0, 0), 1, mk_result(0, 0, 0, 0, 0, 1)});
    drill.push_back('{mk_locate(32'h7fffffff, 0, 0, 7), 1, mk_result(0, 0, 0, 0, 0, 1)});
    drill.push_back('{mk_locate(32'h80000000, 0, 0, 0), 1, mk_result(0, 0, 0, 0, 0, 1)});
    // Out-of-range loads are dropped.
    drill.push_back('{mk_load(REQ_BOUNDARY, 0, 3, 0, -1), 0, '0});
    drill.push_back('{mk_load(REQ_SHAPE, 0, 0, 31, 0), 0, '0});
    // Links keep only the low nibble: these upper-bit patterns mean no subgrid.
    drill.push_back('{mk_link(0, 1, 0, 0, 0), 0, '0});
    drill[$].beat.load_value[3:0] = 4'd0;
    drill[$].beat.load_value = 32'hfffffff0;
    drill.push_back('{mk_link(0, 1, 0, 0, 0), 0, '0});
    drill[$].beat.load_value = 32'h80000000;
    drill.push_back('{mk_locate(3 * one / 2, one / 2, one / 2, 5), 0, '0});
    // Link to a grid with zero or negative cube size.
    drill.push_back('{mk_load(REQ_SHAPE, 1, 0, 1, 0), 0, '0});
    drill.push_back('{mk_load(REQ_SHAPE, 1, 1, 1, -one), 0, '0});
    drill.push_back('{mk_load(REQ_SHAPE, 1, 2, 16, 32'h80000000), 0, '0});
    drill.push_back('{mk_link(0, 0, 0, 0, 1), 0, '0});
    drill.push_back('{mk_locate(one / 4, one / 4, one / 4, 2), 0, '0});

    foreach (drill[i]) begin
      if (drill[i].beat.req_type == REQ_LOCATE) begin
        touched_unloaded = 1'b0;
        walk_cells(drill[i].beat, res);
      end
      offer(drill[i].beat, drill[i].typed, drill[i].want, res);
    end

    // Clear the links again and search the upper cell once more.
    drain();
    send_load(mk_link(0, 1, 0, 0, 0));
    send_load(mk_load(REQ_LINK, 0, 0, 0, 0));
    begin
      in_item_t it;
      it = mk_link(0, 1, 0, 0, 0);
      it.load_value = 32'h7fff_fff0;
      send_load(it);
      it = mk_locate(3 * one / 2, one / 2, one / 2, 5);
      touched_unloaded = 1'b0;
      walk_cells(it, res);
      offer(it, 1'b0, '0, res);
    end

    // Random phases over a four-grid hierarchy, tolerance at its extremes, a random value and the default.
    build_hierarchy();
    tol_plan = '{16'd0, 16'hffff, 16'($urandom_range(1, 2000)), 16'd66};
    for (int ph = 0; ph < 4; ph++) begin
      write_tolerance(tol_plan[ph]);
      rx_busy_pct = (ph == 1) ? 0 : 25;
      tx_gap_pct  = (ph == 3) ? 0 : 25;
      if (ph == 2) hold_left = 3000;  // block fills and stalls its input
      sent = 0;
      while (sent < 75) begin
        random_beat(counted);
        if (counted) sent++;
        if ($urandom_range(0, 39) == 0) drain();  // let the results run dry
      end
    end

    drain();
    repeat (1500) @(posedge clk_i);
    if (mismatches == 0 && cell_trail.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/ngcl_pkg.sv
sv/ngcl_div.sv
sv/ngcl_store.sv
sv/nested_grid_cell_locator.sv
test/nested_grid_cell_locator_tb.sv
